[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define STBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define STBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/stbs_pkg.sv]
// Package: sizes, opcodes, entry and compare types, key normalisation.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = 6;
  localparam int OP_W        = 2;
  localparam int AW          = $clog2(MAX_ENTRIES);
  localparam int CW          = $clog2(MAX_ENTRIES + 1);

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  // One slot of the sorted copy: key and its load position
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AW-1:0]    pos;
  } entry_t;

  // Result of the shared comparator (a against b)
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  // Zero the first NUL or newline byte and all bytes after it; keep KEY_BYTES bytes
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic             stop;
    logic [7:0]       ch;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      ch = raw[KEY_W-1-8*b -: 8];
      if (b >= KEY_BYTES || ch == 8'h00 || ch == NEWLINE_BYTE) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[KEY_W-1-8*b -: 8] = ch;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/stbs_in_if.sv]
// Request channel into the block: opcode and key.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [stbs_pkg::OP_W-1:0]   opcode;
  logic [stbs_pkg::KEY_W-1:0]  key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

[rtl/core/stbs_out_if.sv]
// Result channel out of the block: found flag and load position.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [stbs_pkg::IDX_W-1:0]  match_index;

  modport source (output valid, output found, output match_index, input ready);
  modport sink   (input valid, input found, input match_index, output ready);
endinterface

`default_nettype wire

[rtl/core/sort_then_binary_search_key.sv]
// Top level: key table, exchange sort of a copy, binary search over it.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          opcode[1:0], key[63:0]
//  out_ch    out  valid/ready          found, match_index[5:0]
//
// Clear and append complete in the idle state; the block is ready again at once.
// A search over n keys copies the table into the sorted RAM, then sorts it
// with one compare per cycle while scanning a pass, through the shared comparator
// and the sorted RAM's read/write port pair, then looks the key up by binary search.
// Reset clears the fill count and control state only; no sweep of the RAMs is needed.
// A result waits in the output register; only the next result stalls on it.
`timescale 1ns / 1ps
`default_nettype none

module sort_then_binary_search_key (
  input wire logic     clk,
  input wire logic     rst_n,
  stbs_in_if.sink      in_ch,
  stbs_out_if.source   out_ch
);

  localparam int AW    = stbs_pkg::AW;
  localparam int CW    = stbs_pkg::CW;
  localparam int KEY_W = stbs_pkg::KEY_W;
  localparam int IDX_W = stbs_pkg::IDX_W;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_COPY     = 8'b0000_0010,
    ST_LOADJ    = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_PUTJ     = 8'b0001_0000,
    ST_SRCH_RD  = 8'b0010_0000,
    ST_SRCH_CMP = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [KEY_W-1:0]     target_r, target_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic                 cur_load_r, cur_load_nxt;
  stbs_pkg::entry_t     cur_r, cur_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;

  logic                 in_fire;
  logic                 key_we;
  logic [AW-1:0]        key_raddr;
  logic [KEY_W-1:0]     key_rdata;
  logic                 srt_we;
  logic [AW-1:0]        srt_waddr;
  stbs_pkg::entry_t     srt_wdata;
  logic [AW-1:0]        srt_raddr;
  stbs_pkg::entry_t     srt_rdata;
  logic [KEY_W-1:0]     cmp_a, cmp_b;
  stbs_pkg::cmp_res_t   cmp_res;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic                 table_full;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign table_full   = (count_r >= CW'(stbs_pkg::MAX_ENTRIES));

  // key table: appended in load order, read back during the copy
  assign key_we = in_fire && (in_ch.opcode == stbs_pkg::OP_APPEND) && !table_full;

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (stbs_pkg::MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count_r[AW-1:0]),
    .wdata (stbs_pkg::normalize_key(in_ch.key)),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // sorted copy with load positions
  stbs_ram #(
    .WIDTH ($bits(stbs_pkg::entry_t)),
    .DEPTH (stbs_pkg::MAX_ENTRIES)
  ) u_sort_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  stbs_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // floor midpoint of lo and hi-1 (hi held exclusive)
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    cur_load_nxt  = cur_load_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;

    key_raddr = idx_r[AW-1:0];
    srt_we    = 1'b0;
    srt_waddr = pend_addr_r;
    srt_wdata = cur_r;
    srt_raddr = idx_r[AW-1:0];
    cmp_a     = cur_r.key;
    cmp_b     = srt_rdata.key;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            stbs_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            stbs_pkg::OP_APPEND: begin
              if (!table_full) begin
                count_nxt = count_r + CW'(1);
              end
            end
            stbs_pkg::OP_SEARCH: begin
              target_nxt    = stbs_pkg::normalize_key(in_ch.key);
              idx_nxt       = '0;
              pend_v_nxt    = 1'b0;
              res_found_nxt = 1'b0;
              res_idx_nxt   = '0;
              state_nxt     = ST_COPY;
            end
            default: begin
            end
          endcase
        end
      end

      // stream the table into the sorted RAM, one read ahead of the write
      ST_COPY: begin
        key_raddr     = idx_r[AW-1:0];
        pend_v_nxt    = (idx_r < count_r);
        pend_addr_nxt = idx_r[AW-1:0];
        idx_nxt       = idx_r + CW'(1);
        if (pend_v_r) begin
          srt_we    = 1'b1;
          srt_waddr = pend_addr_r;
          srt_wdata = '{key: key_rdata, pos: pend_addr_r};
        end
        if (idx_r == count_r) begin
          if (count_r < CW'(2)) begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = ST_SRCH_RD;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_LOADJ;
          end
        end
      end

      // fetch the first slot of the pass into the running register
      ST_LOADJ: begin
        srt_raddr    = j_r;
        cur_load_nxt = 1'b1;
        idx_nxt      = CW'(j_r) + CW'(1);
        pend_v_nxt   = 1'b0;
        state_nxt    = ST_SCAN;
      end

      // one compare per cycle: swap leaves the larger key behind at slot i
      ST_SCAN: begin
        srt_raddr     = idx_r[AW-1:0];
        cur_load_nxt  = 1'b0;
        pend_v_nxt    = (idx_r < count_r);
        pend_addr_nxt = idx_r[AW-1:0];
        if (idx_r < count_r) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (cur_load_r) begin
          cur_nxt = srt_rdata;
        end else if (pend_v_r && cmp_res.gt) begin
          srt_we    = 1'b1;
          srt_waddr = pend_addr_r;
          srt_wdata = cur_r;
          cur_nxt   = srt_rdata;
        end
        if (idx_r == count_r) begin
          state_nxt = ST_PUTJ;
        end
      end

      // settle slot j, open the next pass
      ST_PUTJ: begin
        srt_we    = 1'b1;
        srt_waddr = j_r;
        srt_wdata = cur_r;
        j_nxt     = j_r + AW'(1);
        if (CW'(j_r) + CW'(2) == count_r) begin
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = ST_SRCH_RD;
        end else begin
          srt_raddr    = j_r + AW'(1);
          cur_load_nxt = 1'b1;
          idx_nxt      = CW'(j_r) + CW'(2);
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end

      // binary search: issue the midpoint read
      ST_SRCH_RD: begin
        if (lo_r < hi_r) begin
          srt_raddr = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = ST_SRCH_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SRCH_CMP: begin
        cmp_a = srt_rdata.key;
        cmp_b = target_r;
        if (cmp_res.eq) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = IDX_W'(srt_rdata.pos);
          state_nxt     = ST_DONE;
        end else if (cmp_res.gt) begin
          hi_nxt    = mid_r;
          state_nxt = ST_SRCH_RD;
        end else begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = ST_SRCH_RD;
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      cur_load_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      cur_load_r  <= cur_load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    idx_r       <= idx_nxt;
    j_r         <= j_nxt;
    pend_addr_r <= pend_addr_nxt;
    cur_r       <= cur_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_index = out_idx_r;

endmodule

`default_nettype wire

[rtl/core/stbs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/stbs_cmp.sv]
// Shared 64-bit unsigned key comparator used by both sort and search.
`timescale 1ns / 1ps
`default_nettype none

module stbs_cmp (
  input  wire logic [stbs_pkg::KEY_W-1:0] a,
  input  wire logic [stbs_pkg::KEY_W-1:0] b,
  output stbs_pkg::cmp_res_t              res
);

  // a > b decides a swap or moves hi down; a == b ends a search
  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

[rtl/core/stbs_checker.sv]
// Port-level checks on the top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stbs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [stbs_pkg::OP_W-1:0]   in_opcode,
  input wire logic                        out_valid,
  input wire logic                        out_ready
);

  logic in_fire;
  logic is_search;

  assign in_fire   = in_valid && in_ready;
  assign is_search = (in_opcode == stbs_pkg::OP_SEARCH);

  // a result request stays offered until taken
  `STBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // a search keeps the block busy on the next cycle
  `STBS_ASSERT_NXT(a_search_busy, in_fire && is_search, !in_ready, "ready right after a search")
  // clear and append leave the block ready on the next cycle
  `STBS_ASSERT_NXT(a_load_quick, in_fire && !is_search, in_ready, "busy after a load")
  // a new result only comes out of a running search
  `STBS_ASSERT_IMP(a_result_src, $rose(out_valid), $past(!in_ready), "result without a search")

endmodule

bind sort_then_binary_search_key stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire
